[hw/rtl/skf_pkg.sv]
package skf_pkg;

    localparam int WORD_W   = 32;
    localparam int VAR_W    = 31;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [VAR_W-1:0]         t_var;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;

    localparam t_cfg_idx CFG_TRANSITION = 3'd0;
    localparam t_cfg_idx CFG_OBSERVE    = 3'd1;
    localparam t_cfg_idx CFG_PROC_NOISE = 3'd2;
    localparam t_cfg_idx CFG_MEAS_NOISE = 3'd3;
    localparam t_cfg_idx CFG_INIT_EST   = 3'd4;
    localparam t_cfg_idx CFG_INIT_VAR   = 3'd5;

    localparam t_word RST_TRANSITION = 32'sd65536;
    localparam t_word RST_OBSERVE    = 32'sd65536;
    localparam t_var  RST_PROC_NOISE = 31'd7;
    localparam t_var  RST_MEAS_NOISE = 31'd131072;
    localparam t_word RST_INIT_EST   = 32'sd65536;
    localparam t_var  RST_INIT_VAR   = 31'd655360000;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[hw/rtl/skf_item_if.sv]
interface skf_item_if
    import skf_pkg::*;
();
    logic  valid;
    logic  ready;
    t_word measurement;
    logic  restart;

    modport source (output valid, output measurement, output restart, input ready);
    modport sink   (input valid, input measurement, input restart, output ready);
endinterface

[hw/rtl/skf_result_if.sv]
interface skf_result_if
    import skf_pkg::*;
();
    logic  valid;
    logic  ready;
    t_word estimate;
    t_var  variance;
    logic  singular;

    modport source (output valid, output estimate, output variance, output singular,
                    input ready);
    modport sink   (input valid, input estimate, input variance, input singular,
                    output ready);
endinterface

[hw/rtl/skf_mulq.sv]
module skf_mulq
    import skf_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic  i_clk,
    input  t_word i_a,
    input  t_word i_b,
    output t_word o_res
);

    localparam int          WORD_BITS = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam logic [63:0] W_MAX     = (64'd1 << (WORD_BITS - 1)) - 64'd1;
    localparam logic [63:0] HALF      = 64'd1 << (FRAC_BITS - 1);

    logic signed [63:0] r_prod;
    t_word              r_res;
    t_word              n_res;
    logic               w_neg;
    logic [63:0]        w_mag;
    logic [63:0]        w_rnd;

    // round magnitude to nearest, ties away from zero, then clamp
    always_comb begin
        w_neg = r_prod[63];
        w_mag = w_neg ? 64'(-r_prod) : 64'(r_prod);
        w_rnd = (w_mag + HALF) >> FRAC_BITS;
        if (!w_neg) begin
            n_res = (w_rnd > W_MAX) ? 32'(W_MAX) : 32'(w_rnd);
        end else begin
            n_res = (w_rnd > W_MAX) ? 32'(-(W_MAX + 64'd1)) : 32'(-w_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_res  <= n_res;
    end

    assign o_res = r_res;

endmodule

[hw/rtl/skf_divq.sv]
module skf_divq
    import skf_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_word     i_num,
    input  t_word     i_den,
    output t_div_stat o_stat,
    output t_word     o_quot
);

    localparam int          WORD_BITS = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int          QW        = 32;
    localparam int          CW        = $clog2(QW);
    localparam int          NW        = QW + FRAC_BITS;
    localparam logic [32:0] LIM       = 33'd1 << (WORD_BITS - 1);

    typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIN} t_dv_state;

    t_dv_state      r_state;
    logic [CW-1:0]  r_cnt;
    logic           r_done;
    logic [31:0]    r_rem;
    logic [31:0]    r_q;
    logic [30:0]    r_d;
    logic           r_neg;
    logic           r_ovf;
    t_word          r_quot;

    logic [31:0]    w_mag;
    logic [NW-1:0]  w_n;
    logic [31:0]    w_t;
    logic           w_ge;
    logic [32:0]    w_qq;
    t_word          w_res;

    always_comb begin
        w_mag = i_num[31] ? 32'(-i_num) : 32'(i_num);
        w_n   = (NW'(w_mag) << FRAC_BITS) + NW'(i_den[30:1]);
        w_t   = {r_rem[30:0], r_q[31]};
        w_ge  = w_t >= {1'b0, r_d};
        w_qq  = (r_ovf || ({1'b0, r_q} > LIM)) ? LIM : {1'b0, r_q};
        if (r_neg) begin
            w_res = 32'(-{1'b0, w_qq});
        end else begin
            w_res = (w_qq == LIM) ? 32'(LIM - 33'd1) : 32'(w_qq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                DV_IDLE: begin
                    if (i_start) begin
                        // upper part at or above the divisor means a quotient past 32 bits
                        r_rem   <= 32'(w_n[NW-1:QW]);
                        r_q     <= w_n[QW-1:0];
                        r_d     <= i_den[30:0];
                        r_neg   <= i_num[31];
                        r_ovf   <= 32'(w_n[NW-1:QW]) >= {1'b0, i_den[30:0]};
                        r_cnt   <= '0;
                        r_state <= DV_RUN;
                    end
                end
                DV_RUN: begin
                    r_rem <= w_ge ? (w_t - {1'b0, r_d}) : w_t;
                    r_q   <= {r_q[30:0], w_ge};
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(QW - 1)) begin
                        r_state <= DV_FIN;
                    end
                end
                DV_FIN: begin
                    r_quot  <= w_res;
                    r_done  <= 1'b1;
                    r_state <= DV_IDLE;
                end
                default: r_state <= DV_IDLE;
            endcase
        end
    end

    assign o_stat.busy = (r_state != DV_IDLE);
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

[hw/rtl/scalar_kalman_filter_top.sv]
// One-dimensional Kalman filter over a stream of Q16.16 range measurements.
// i_item carries one measurement and a restart bit per beat; restart reloads
// the initial estimate and variance before that step. o_result returns one
// beat per measurement: the updated estimate, its variance and a singular
// flag that marks a zero gain denominator (gain forced to 0).
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write them only while the block is idle, which the block does not
// enforce. Indexes past the last register are ignored. Every multiply goes
// through one shared multiplier (product register, then rounding register),
// and the gain comes from a shift-subtract divider that retires one quotient
// bit per cycle. Each step runs 10 multiplies, plus one divide when the gain
// denominator is not zero; a zero denominator skips the divider.
// One item is in flight at a time and the next beat is taken the cycle after
// the result loads, so a new item is not taken until the last one is through.
// The result sits in an output register: a new item is accepted while it
// waits, and the step stalls at its last multiply until the slot frees.
// Reset loads all registers with their defaults and the state with the
// initial estimate and variance; the block is ready the cycle after reset.
module scalar_kalman_filter_top
    import skf_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  t_cfg_idx          i_cfg_idx,
    input  logic [WORD_W-1:0] i_cfg_data,
    skf_item_if.sink          i_item,
    skf_result_if.source      o_result
);

    localparam int                 WORD_BITS = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam logic signed [35:0] W_MAX36   = (36'sd1 <<< (WORD_BITS - 1)) - 36'sd1;
    localparam logic signed [35:0] W_MIN36   = -W_MAX36 - 36'sd1;
    localparam logic signed [35:0] ONE36     = 36'sd1 <<< FRAC_BITS;
    localparam logic [1:0]         MUL_LAT   = 2'd2;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} t_state;
    typedef enum logic [3:0] {
        OP_XP, OP_FP, OP_PP, OP_HP, OP_DEN, OP_NUM, OP_HX, OP_X, OP_KH, OP_P
    } t_op;

    function automatic t_word sat_w(input logic signed [35:0] v);
        t_word res;
        priority if (v > W_MAX36) begin
            res = 32'(W_MAX36);
        end else if (v < W_MIN36) begin
            res = 32'(W_MIN36);
        end else begin
            res = 32'(v);
        end
        return res;
    endfunction

    function automatic t_word sat_v(input logic signed [35:0] v);
        t_word res;
        if (v < 36'sd0) begin
            res = '0;
        end else begin
            res = sat_w(v);
        end
        return res;
    endfunction

    // configuration
    t_word r_cfg_f;
    t_word r_cfg_h;
    t_var  r_cfg_q;
    t_var  r_cfg_r;
    t_word r_cfg_x0;
    t_var  r_cfg_p0;

    // sequencer and working values
    t_state     r_state;
    t_op        r_op;
    logic [1:0] r_phase;
    t_word      r_x;
    t_word      r_p;
    t_word      r_z;
    t_word      r_xp;
    t_word      r_t;
    t_word      r_pp;
    t_word      r_den;
    t_word      r_k;
    t_word      r_innov;
    t_word      r_omk;
    logic       r_sing;

    // output slot
    logic       r_ovalid;
    t_word      r_o_est;
    t_var       r_o_var;
    logic       r_o_sing;

    t_word      w_f;
    t_word      w_h;
    t_word      w_q;
    t_word      w_r;
    t_word      w_init_x;
    t_word      w_init_p;
    t_word      w_a;
    t_word      w_b;
    t_word      w_mres;
    t_word      w_p_new;
    t_word      w_quot;
    t_div_stat  w_div_stat;
    logic       w_consume;
    logic       w_div_start;
    logic       w_out_free;
    logic       w_out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_f  <= RST_TRANSITION;
            r_cfg_h  <= RST_OBSERVE;
            r_cfg_q  <= RST_PROC_NOISE;
            r_cfg_r  <= RST_MEAS_NOISE;
            r_cfg_x0 <= RST_INIT_EST;
            r_cfg_p0 <= RST_INIT_VAR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TRANSITION: r_cfg_f  <= i_cfg_data;
                CFG_OBSERVE:    r_cfg_h  <= i_cfg_data;
                CFG_PROC_NOISE: r_cfg_q  <= i_cfg_data[VAR_W-1:0];
                CFG_MEAS_NOISE: r_cfg_r  <= i_cfg_data[VAR_W-1:0];
                CFG_INIT_EST:   r_cfg_x0 <= i_cfg_data;
                CFG_INIT_VAR:   r_cfg_p0 <= i_cfg_data[VAR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_f      = sat_w(36'(r_cfg_f));
        w_h      = sat_w(36'(r_cfg_h));
        w_q      = sat_w(36'({1'b0, r_cfg_q}));
        w_r      = sat_w(36'({1'b0, r_cfg_r}));
        w_init_x = sat_w(36'(r_cfg_x0));
        w_init_p = sat_v(36'({1'b0, r_cfg_p0}));
        w_p_new  = sat_v(36'(w_mres));
    end

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_op)
            OP_XP:   begin w_a = w_f;   w_b = r_x;     end
            OP_FP:   begin w_a = w_f;   w_b = r_p;     end
            OP_PP:   begin w_a = r_t;   w_b = w_f;     end
            OP_HP:   begin w_a = w_h;   w_b = r_pp;    end
            OP_DEN:  begin w_a = r_t;   w_b = w_h;     end
            OP_NUM:  begin w_a = r_pp;  w_b = w_h;     end
            OP_HX:   begin w_a = w_h;   w_b = r_xp;    end
            OP_X:    begin w_a = r_k;   w_b = r_innov; end
            OP_KH:   begin w_a = r_k;   w_b = w_h;     end
            OP_P:    begin w_a = r_omk; w_b = r_pp;    end
            default: begin w_a = '0;    w_b = '0;      end
        endcase
    end

    skf_mulq #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mulq (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_res (w_mres)
    );

    assign w_consume   = (r_state == ST_MUL) && (r_phase == MUL_LAT);
    assign w_div_start = w_consume && (r_op == OP_NUM) && (r_den > 32'sd0);
    assign w_out_free  = !r_ovalid || o_result.ready;
    assign w_out_load  = w_consume && (r_op == OP_P) && w_out_free;

    skf_divq #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_divq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_mres),
        .i_den   (r_den),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= OP_XP;
            r_phase  <= '0;
            r_ovalid <= 1'b0;
            r_sing   <= 1'b0;
            r_x      <= sat_w(36'(RST_INIT_EST));
            r_p      <= sat_v(36'({1'b0, RST_INIT_VAR}));
        end else begin
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_result.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_item.valid) begin
                        r_z    <= i_item.measurement;
                        r_sing <= 1'b0;
                        if (i_item.restart) begin
                            r_x <= w_init_x;
                            r_p <= w_init_p;
                        end
                        r_op    <= OP_XP;
                        r_phase <= '0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (r_phase != MUL_LAT) begin
                        r_phase <= r_phase + 2'd1;
                    end else begin
                        // hold at the last multiply until the output slot frees
                        if (r_op != OP_P || w_out_free) begin
                            r_phase <= '0;
                        end
                        unique case (r_op)
                            OP_XP: begin
                                r_xp <= w_mres;
                                r_op <= OP_FP;
                            end
                            OP_FP: begin
                                r_t  <= w_mres;
                                r_op <= OP_PP;
                            end
                            OP_PP: begin
                                r_pp <= sat_v(36'(w_mres) + 36'(w_q));
                                r_op <= OP_HP;
                            end
                            OP_HP: begin
                                r_t  <= w_mres;
                                r_op <= OP_DEN;
                            end
                            OP_DEN: begin
                                r_den <= sat_w(36'(w_mres) + 36'(w_r));
                                r_op  <= OP_NUM;
                            end
                            OP_NUM: begin
                                if (r_den > 32'sd0) begin
                                    r_state <= ST_DIV;
                                end else begin
                                    r_k    <= '0;
                                    r_sing <= 1'b1;
                                    r_op   <= OP_HX;
                                end
                            end
                            OP_HX: begin
                                r_innov <= sat_w(36'(r_z) - 36'(w_mres));
                                r_op    <= OP_X;
                            end
                            OP_X: begin
                                r_x  <= sat_w(36'(r_xp) + 36'(w_mres));
                                r_op <= OP_KH;
                            end
                            OP_KH: begin
                                r_omk <= sat_w(ONE36 - 36'(w_mres));
                                r_op  <= OP_P;
                            end
                            OP_P: begin
                                if (w_out_free) begin
                                    r_p      <= w_p_new;
                                    r_o_est  <= r_x;
                                    r_o_var  <= w_p_new[VAR_W-1:0];
                                    r_o_sing <= r_sing;
                                    r_state  <= ST_IDLE;
                                end
                            end
                            default: r_op <= OP_XP;
                        endcase
                    end
                end
                ST_DIV: begin
                    if (w_div_stat.done) begin
                        r_k     <= w_quot;
                        r_op    <= OP_HX;
                        r_phase <= '0;
                        r_state <= ST_MUL;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_item.ready      = (r_state == ST_IDLE);
    assign o_result.valid    = r_ovalid;
    assign o_result.estimate = r_o_est;
    assign o_result.variance = r_o_var;
    assign o_result.singular = r_o_sing;

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("divider started while busy");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (w_div_stat.busy || w_div_stat.done))
        else $error("waiting on an idle divider");

    a_var_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_p[WORD_W-1])
        else $error("variance went negative");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_state == ST_MUL && r_op == OP_XP))
        else $error("accepted beat did not start a step");

    a_sing_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sing |-> (r_k == '0))
        else $error("singular step with nonzero gain");

endmodule
